FILE: src/direction_vector_to_hue_color_core_defines.svh
// Assertion macros for the direction-to-color core.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef DIRECTION_VECTOR_TO_HUE_COLOR_CORE_DEFINES_SVH
`define DIRECTION_VECTOR_TO_HUE_COLOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DVHC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dvhc: assertion failed");
// next-cycle implication
`define DVHC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dvhc: assertion failed");
`else
`define DVHC_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define DVHC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: src/dvhc_pkg.sv
// Shared constants, sector codes and helper functions for the
// direction-to-color core. No dependencies.
package dvhc_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int CHANNEL_BITS_DEF    = 8;

  localparam int MAG_W  = 32;  // normalized magnitudes
  localparam int XY_W   = 36;  // CORDIC x/y datapath, signed
  localparam int ANG_W  = 32;  // angle accumulator, signed
  localparam int SUM_W  = 64;  // sum of squares
  localparam int ROOT_W = 32;  // integer square root
  localparam int REM_W  = 36;  // square root partial remainder
  localparam int HUE_W  = 15;
  localparam int T_W    = 12;
  localparam int OUT_W  = 8;

  localparam logic signed [ANG_W-1:0] ANG_180 = 32'sd754974720;
  localparam logic signed [ANG_W-1:0] ANG_360 = 32'sd1509949440;
  localparam logic signed [ANG_W-1:0] ANG_HALF_LSB = 32'sd32768;
  localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;
  localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;

  // 60 degree sectors of the color wheel
  typedef enum logic [2:0] {
    SEC_R2Y = 3'd0,
    SEC_Y2G = 3'd1,
    SEC_G2C = 3'd2,
    SEC_C2B = 3'd3,
    SEC_B2M = 3'd4,
    SEC_M2R = 3'd5
  } sector_t;

  // atan(2^-i) in 2^-16 of 1/64 degree
  function automatic logic signed [ANG_W-1:0] atan_tab(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = 32'sd188743680;
      5'd1:  v = 32'sd111421900;
      5'd2:  v = 32'sd58872272;
      5'd3:  v = 32'sd29884485;
      5'd4:  v = 32'sd15000234;
      5'd5:  v = 32'sd7507429;
      5'd6:  v = 32'sd3754631;
      5'd7:  v = 32'sd1877430;
      5'd8:  v = 32'sd938729;
      5'd9:  v = 32'sd469366;
      5'd10: v = 32'sd234683;
      5'd11: v = 32'sd117342;
      5'd12: v = 32'sd58671;
      5'd13: v = 32'sd29335;
      5'd14: v = 32'sd14668;
      5'd15: v = 32'sd7334;
      5'd16: v = 32'sd3667;
      5'd17: v = 32'sd1833;
      5'd18: v = 32'sd917;
      5'd19: v = 32'sd458;
      5'd20: v = 32'sd229;
      5'd21: v = 32'sd115;
      5'd22: v = 32'sd57;
      5'd23: v = 32'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

  // position of the leading one, 0 for a zero word
  function automatic logic [4:0] msb_pos(input logic [MAG_W-1:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

FILE: src/direction_vector_to_hue_color_core.sv
// Direction vector to color-wheel RGB, fully pipelined.
// Depends on dvhc_pkg and direction_vector_to_hue_color_core_defines.svh.
//
// Usage:
//  - Input channel in_valid/in_ready carries one request: dir_x, dir_y, dir_z.
//  - Output channel out_valid/out_ready returns red, green, blue and
//    hue_angle (1/64 degree) for each request, in order.
//  - The pipeline has 2 input and normalize stages, 2 stages for squares
//    and their sum, 32 square-root digit stages, 3 stages for the
//    numerators, one stage per quotient bit of the two channel dividers
//    and one output register. The CORDIC (CORDIC_STAGES stages) runs
//    beside the square root and adds no stages.
//  - Throughput is one request per cycle while the receiver does not stall;
//    every stage is registered and carries a valid bit.
//  - A receiver stall freezes the whole pipeline: in_ready follows
//    !out_valid || out_ready, so nothing is dropped or repeated.
//  - Synchronous reset clears all valid bits; no request is in flight after.
//  - A zero vector returns pure red with hue 0.
`include "direction_vector_to_hue_color_core_defines.svh"
module direction_vector_to_hue_color_core
  import dvhc_pkg::*;
#(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
  parameter int CHANNEL_BITS    = CHANNEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COMPONENT_WIDTH-1:0] dir_x,
  input  logic signed [COMPONENT_WIDTH-1:0] dir_y,
  input  logic signed [COMPONENT_WIDTH-1:0] dir_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [OUT_W-1:0]                  red,
  output logic [OUT_W-1:0]                  green,
  output logic [OUT_W-1:0]                  blue,
  output logic [HUE_W-1:0]                  hue_angle
);

  localparam int W  = COMPONENT_WIDTH;
  localparam int CS = CORDIC_STAGES;
  localparam int CB = CHANNEL_BITS;

  // stage numbers
  localparam int P_IN   = 1;
  localparam int P_NRM  = 2;
  localparam int P_SQ   = 3;
  localparam int P_SUM  = 4;
  localparam int P_ROOT = P_SUM + ROOT_W;
  localparam int P_PREP = P_ROOT + 1;
  localparam int P_MUL  = P_ROOT + 2;
  localparam int P_NUM  = P_ROOT + 3;
  localparam int P_OUT  = P_NUM + CB + 1;
  localparam int P_CEND = P_NRM + CS;
  localparam int P_HUE  = P_CEND + 1;
  localparam int P_SEC  = P_HUE + 1;

  localparam int D_W    = ROOT_W + 1;
  localparam int Z3_W   = MAG_W + 12;
  localparam int DEN_W  = D_W + 12;
  localparam int PROD_W = D_W + T_W;
  localparam int V_W    = PROD_W + 1;
  localparam int NUM_W  = V_W + CB + 1;

  localparam logic [CB-1:0] MAXC = '1;
  localparam logic [OUT_W-1:0] FULL8 = OUT_W'(16'(MAXC));

  localparam logic [HUE_W-1:0] HB1 = HUE_SECTOR;
  localparam logic [HUE_W-1:0] HB2 = 15'(2 * 3840);
  localparam logic [HUE_W-1:0] HB3 = 15'(3 * 3840);
  localparam logic [HUE_W-1:0] HB4 = 15'(4 * 3840);
  localparam logic [HUE_W-1:0] HB5 = 15'(5 * 3840);

  logic [P_OUT:1] vld;
  logic           adv;

  // global advance: the last stage is empty or being taken
  assign adv       = !vld[P_OUT] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[P_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[P_OUT-1:1], in_valid};
    end
  end

  // ---------------- pipeline registers ----------------
  logic signed [W-1:0] x1, y1, z1;

  logic signed [XY_W-1:0]  cxp [P_NRM:P_CEND];
  logic signed [XY_W-1:0]  cyp [P_NRM:P_CEND];
  logic signed [ANG_W-1:0] cap [P_NRM:P_CEND];
  logic                    xyz_p [P_NRM:P_CEND];
  logic                    zr_p  [P_NRM:P_OUT-1];
  logic [MAG_W-1:0]        z_p   [P_NRM:P_ROOT];
  logic [MAG_W-1:0]        ax2, ay2;

  logic [SUM_W-1:0]  sqx, sqy, sqz;
  logic [SUM_W-1:0]  rad_p [P_SUM:P_ROOT];
  logic [REM_W-1:0]  rr_p  [P_SUM:P_ROOT];
  logic [ROOT_W-1:0] rq_p  [P_SUM:P_ROOT];

  logic [HUE_W-1:0]  hue_p [P_HUE:P_OUT-1];
  sector_t           sec_p [P_SEC:P_OUT-1];
  logic [T_W-1:0]    t_p   [P_SEC:P_PREP];

  logic [DEN_W-1:0]  den_p [P_PREP:P_OUT-1];
  logic [Z3_W-1:0]   z3_p  [P_PREP:P_MUL];
  logic [D_W-1:0]    dmz;
  logic [PROD_W-1:0] prod;

  logic [NUM_W-1:0]  nm_p [P_NUM:P_OUT-1];
  logic [NUM_W-1:0]  nl_p [P_NUM:P_OUT-1];
  logic [CB-1:0]     qm_p [P_NUM:P_OUT-1];
  logic [CB-1:0]     ql_p [P_NUM:P_OUT-1];

  // ---------------- normalize (stage 2) ----------------
  logic signed [MAG_W:0]   sx, sy, sz, nx, ny;
  logic [MAG_W-1:0]        ax, ay, az, mxy, big;
  logic [4:0]              ph, pl, sh_h, sh_l;
  logic signed [XY_W-1:0]  nxw, nyw;

  assign sx = (MAG_W+1)'(x1);
  assign sy = (MAG_W+1)'(y1);
  assign sz = (MAG_W+1)'(z1);
  assign ax = sx[MAG_W] ? MAG_W'(-sx) : sx[MAG_W-1:0];
  assign ay = sy[MAG_W] ? MAG_W'(-sy) : sy[MAG_W-1:0];
  assign az = sz[MAG_W] ? MAG_W'(-sz) : sz[MAG_W-1:0];
  assign mxy = (ay > ax) ? ay : ax;
  assign big = (az > mxy) ? az : mxy;
  assign ph  = msb_pos(mxy);
  assign pl  = msb_pos(big);
  assign sh_h = (ph < 5'd29) ? 5'(5'd29 - ph) : '0;
  assign sh_l = (pl < 5'd30) ? 5'(5'd30 - pl) : '0;
  // left half-plane: turn by 180 degrees
  assign nx  = sx[MAG_W] ? -sx : sx;
  assign ny  = sx[MAG_W] ? -sy : sy;
  assign nxw = XY_W'(nx);
  assign nyw = XY_W'(ny);

  // ---------------- CORDIC vectoring stages ----------------
  logic signed [XY_W-1:0]  cx_next [P_NRM+1:P_CEND];
  logic signed [XY_W-1:0]  cy_next [P_NRM+1:P_CEND];
  logic signed [ANG_W-1:0] ca_next [P_NRM+1:P_CEND];

  for (genvar k = 1; k <= CS; k++) begin : g_cordic
    logic signed [XY_W-1:0] dx, dy;
    assign dx = cyp[P_NRM+k-1] >>> (k - 1);
    assign dy = cxp[P_NRM+k-1] >>> (k - 1);
    always_comb begin
      if (!cyp[P_NRM+k-1][XY_W-1]) begin
        cx_next[P_NRM+k] = cxp[P_NRM+k-1] + dx;
        cy_next[P_NRM+k] = cyp[P_NRM+k-1] - dy;
        ca_next[P_NRM+k] = cap[P_NRM+k-1] + atan_tab(5'(k - 1));
      end else begin
        cx_next[P_NRM+k] = cxp[P_NRM+k-1] - dx;
        cy_next[P_NRM+k] = cyp[P_NRM+k-1] + dy;
        ca_next[P_NRM+k] = cap[P_NRM+k-1] - atan_tab(5'(k - 1));
      end
    end
  end

  // ---------------- hue wrap and round ----------------
  logic signed [ANG_W-1:0] aw, ahs;
  logic [HUE_W-1:0]        h16, hue_next;

  assign aw  = cap[P_CEND][ANG_W-1] ? cap[P_CEND] + ANG_360 : cap[P_CEND];
  assign ahs = aw + ANG_HALF_LSB;
  assign h16 = ahs[ANG_W-2:16];
  assign hue_next = (xyz_p[P_CEND] || (h16 == HUE_FULL)) ? '0 : h16;

  // ---------------- sector and position in sector ----------------
  sector_t          sec_next;
  logic [HUE_W-1:0] hbase, hrem;
  logic [T_W-1:0]   t_next;

  always_comb begin
    if (hue_p[P_HUE] >= HB5) begin
      sec_next = SEC_M2R; hbase = HB5;
    end else if (hue_p[P_HUE] >= HB4) begin
      sec_next = SEC_B2M; hbase = HB4;
    end else if (hue_p[P_HUE] >= HB3) begin
      sec_next = SEC_C2B; hbase = HB3;
    end else if (hue_p[P_HUE] >= HB2) begin
      sec_next = SEC_G2C; hbase = HB2;
    end else if (hue_p[P_HUE] >= HB1) begin
      sec_next = SEC_Y2G; hbase = HB1;
    end else begin
      sec_next = SEC_R2Y; hbase = '0;
    end
    hrem = hue_p[P_HUE] - hbase;
    if (sec_next == SEC_Y2G || sec_next == SEC_C2B || sec_next == SEC_M2R) begin
      t_next = T_W'(HUE_SECTOR - hrem);
    end else begin
      t_next = hrem[T_W-1:0];
    end
  end

  // ---------------- square root, one digit per stage ----------------
  logic [SUM_W-1:0]  rad_next [P_SUM+1:P_ROOT];
  logic [REM_W-1:0]  rr_next  [P_SUM+1:P_ROOT];
  logic [ROOT_W-1:0] rq_next  [P_SUM+1:P_ROOT];

  for (genvar k = P_SUM + 1; k <= P_ROOT; k++) begin : g_root
    logic [REM_W-1:0] rs, trial;
    logic             ge;
    assign rs    = {rr_p[k-1][REM_W-3:0], rad_p[k-1][SUM_W-1:SUM_W-2]};
    assign trial = REM_W'({rq_p[k-1], 2'b01});
    assign ge    = rs >= trial;
    assign rr_next[k]  = ge ? rs - trial : rs;
    assign rq_next[k]  = {rq_p[k-1][ROOT_W-2:0], ge};
    assign rad_next[k] = rad_p[k-1] << 2;
  end

  // ---------------- numerator preparation ----------------
  logic [D_W-1:0]    dd;
  logic [Z3_W-1:0]   z3_next;
  logic [DEN_W-1:0]  den_next;
  logic [D_W-1:0]    dmz_next;
  logic [PROD_W-1:0] prod_next;
  logic [V_W-1:0]    vmid;
  logic [NUM_W-1:0]  nm_init, nl_init, half_den;

  assign dd       = {rq_p[P_ROOT], 1'b0};
  assign z3_next  = (Z3_W'(z_p[P_ROOT]) << 12) - (Z3_W'(z_p[P_ROOT]) << 8);
  assign den_next = (DEN_W'(dd) << 12) - (DEN_W'(dd) << 8);
  assign dmz_next = dd - D_W'(z_p[P_ROOT]);
  assign prod_next = dmz * t_p[P_PREP];
  assign vmid     = V_W'(z3_p[P_MUL]) + V_W'(prod);
  assign half_den = NUM_W'(den_p[P_MUL] >> 1);
  // MAXC * v as (v << CB) - v
  assign nm_init  = (NUM_W'(vmid) << CB) - NUM_W'(vmid) + half_den;
  assign nl_init  = (NUM_W'(z3_p[P_MUL]) << CB) - NUM_W'(z3_p[P_MUL]) + half_den;

  // ---------------- restoring dividers, one quotient bit per stage ----------------
  logic [NUM_W-1:0] nm_next [P_NUM+1:P_OUT-1];
  logic [NUM_W-1:0] nl_next [P_NUM+1:P_OUT-1];
  logic [CB-1:0]    qm_next [P_NUM+1:P_OUT-1];
  logic [CB-1:0]    ql_next [P_NUM+1:P_OUT-1];

  for (genvar k = P_NUM + 1; k <= P_OUT - 1; k++) begin : g_div
    localparam int B = P_NUM + CB - k;
    logic [NUM_W-1:0] dsh;
    logic             gm, gl;
    assign dsh = NUM_W'(den_p[k-1]) << B;
    assign gm  = nm_p[k-1] >= dsh;
    assign gl  = nl_p[k-1] >= dsh;
    always_comb begin
      nm_next[k] = gm ? nm_p[k-1] - dsh : nm_p[k-1];
      nl_next[k] = gl ? nl_p[k-1] - dsh : nl_p[k-1];
      qm_next[k] = qm_p[k-1];
      ql_next[k] = ql_p[k-1];
      qm_next[k][B] = gm;
      ql_next[k][B] = gl;
    end
  end

  // ---------------- channel select ----------------
  logic [OUT_W-1:0] mid8, low8, r_next, g_next, b_next;

  assign mid8 = OUT_W'(16'(qm_p[P_OUT-1]));
  assign low8 = OUT_W'(16'(ql_p[P_OUT-1]));

  always_comb begin
    unique case (sec_p[P_OUT-1])
      SEC_R2Y: begin r_next = FULL8; g_next = mid8;  b_next = low8;  end
      SEC_Y2G: begin r_next = mid8;  g_next = FULL8; b_next = low8;  end
      SEC_G2C: begin r_next = low8;  g_next = FULL8; b_next = mid8;  end
      SEC_C2B: begin r_next = low8;  g_next = mid8;  b_next = FULL8; end
      SEC_B2M: begin r_next = mid8;  g_next = low8;  b_next = FULL8; end
      default: begin r_next = FULL8; g_next = low8;  b_next = mid8;  end
    endcase
    if (zr_p[P_OUT-1]) begin
      r_next = FULL8;
      g_next = '0;
      b_next = '0;
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (adv) begin
      // input register
      x1 <= dir_x;
      y1 <= dir_y;
      z1 <= dir_z;
      // normalize
      cxp[P_NRM]   <= nxw <<< sh_h;
      cyp[P_NRM]   <= nyw <<< sh_h;
      cap[P_NRM]   <= sx[MAG_W] ? ANG_180 : '0;
      xyz_p[P_NRM] <= (mxy == '0);
      zr_p[P_NRM]  <= (big == '0);
      z_p[P_NRM]   <= az << sh_l;
      ax2          <= ax << sh_l;
      ay2          <= ay << sh_l;
      // CORDIC
      for (int k = P_NRM + 1; k <= P_CEND; k++) begin
        cxp[k]   <= cx_next[k];
        cyp[k]   <= cy_next[k];
        cap[k]   <= ca_next[k];
        xyz_p[k] <= xyz_p[k-1];
      end
      hue_p[P_HUE] <= hue_next;
      sec_p[P_SEC] <= sec_next;
      t_p[P_SEC]   <= t_next;
      for (int k = P_HUE + 1; k <= P_OUT - 1; k++) hue_p[k] <= hue_p[k-1];
      for (int k = P_SEC + 1; k <= P_OUT - 1; k++) sec_p[k] <= sec_p[k-1];
      for (int k = P_SEC + 1; k <= P_PREP; k++) t_p[k] <= t_p[k-1];
      for (int k = P_NRM + 1; k <= P_OUT - 1; k++) zr_p[k] <= zr_p[k-1];
      for (int k = P_NRM + 1; k <= P_ROOT; k++) z_p[k] <= z_p[k-1];
      // length
      sqx <= ax2 * ax2;
      sqy <= ay2 * ay2;
      sqz <= z_p[P_NRM] * z_p[P_NRM];
      rad_p[P_SUM] <= sqx + sqy + sqz;
      rr_p[P_SUM]  <= '0;
      rq_p[P_SUM]  <= '0;
      for (int k = P_SUM + 1; k <= P_ROOT; k++) begin
        rad_p[k] <= rad_next[k];
        rr_p[k]  <= rr_next[k];
        rq_p[k]  <= rq_next[k];
      end
      // numerators
      den_p[P_PREP] <= den_next;
      z3_p[P_PREP]  <= z3_next;
      dmz           <= dmz_next;
      z3_p[P_MUL]   <= z3_p[P_PREP];
      prod          <= prod_next;
      for (int k = P_PREP + 1; k <= P_OUT - 1; k++) den_p[k] <= den_p[k-1];
      nm_p[P_NUM] <= nm_init;
      nl_p[P_NUM] <= nl_init;
      qm_p[P_NUM] <= '0;
      ql_p[P_NUM] <= '0;
      for (int k = P_NUM + 1; k <= P_OUT - 1; k++) begin
        nm_p[k] <= nm_next[k];
        nl_p[k] <= nl_next[k];
        qm_p[k] <= qm_next[k];
        ql_p[k] <= ql_next[k];
      end
      // output register
      red       <= r_next;
      green     <= g_next;
      blue      <= b_next;
      hue_angle <= hue_p[P_OUT-1];
    end
  end

  // ---------------- assertions ----------------
  `DVHC_ASSERT_IMPLY(a_hue_range, clk, rst, out_valid, hue_angle < HUE_FULL)
  `DVHC_ASSERT_IMPLY(a_full_chan, clk, rst, out_valid, red == FULL8 || green == FULL8 || blue == FULL8)
  `DVHC_ASSERT_NEXT(a_stall_hold, clk, rst, !adv, vld == $past(vld))
  `DVHC_ASSERT_IMPLY(a_root_rem, clk, rst, vld[P_ROOT], rr_p[P_ROOT] <= (REM_W'(rq_p[P_ROOT]) << 1))
  `DVHC_ASSERT_IMPLY(a_low_le_mid, clk, rst, vld[P_OUT-1] && !zr_p[P_OUT-1], ql_p[P_OUT-1] <= qm_p[P_OUT-1])

endmodule
